// File: src/srs_pkg.sv
// ============================================================================
// srs_pkg : shared types and constants for the 3D stencil relaxation core
// Field widths, register codes, state and tap encodings, divider constants.
// ============================================================================
package srs_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int GRID_SIZE_W = 7;
    localparam int OMEGA_W     = 18;
    localparam int CFG_DATA_W  = 18;
    localparam int CFG_ADDR_W  = 1;
    localparam int MAX_N_DEF   = 64;
    localparam int MIN_N       = 4;

    localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST = 7'd64;
    localparam logic [OMEGA_W-1:0]     OMEGA_RST     = 18'd58982;

    // datapath widths
    localparam int SUM_W  = 35;
    localparam int DIFF_W = 36;
    localparam int PROD_W = DIFF_W + OMEGA_W + 1;
    localparam int NUM_W  = 56;
    localparam int DIV_W  = 40;
    localparam int DIV_STEPS = 5;
    localparam int DIV_CNT_W = 3;
    localparam int SCALE_SH  = 16;

    localparam logic [NUM_W-1:0] HALF_Q = 56'd196608;
    localparam logic [20:0]      RECIP6 = 21'd683;

    localparam logic [1:0] CFG_SETTLE = 2'd3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GRID_SIZE = 1'b0,
        CFG_OMEGA     = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        TAP_CENTRE,
        TAP_I_LO,
        TAP_I_HI,
        TAP_J_LO,
        TAP_J_HI,
        TAP_K_LO,
        TAP_K_HI
    } t_tap;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_WAIT,
        S_DIFF,
        S_MUL,
        S_NUM,
        S_RND,
        S_DIV,
        S_SAT,
        S_OUT
    } t_state;

endpackage

// File: src/stencil_relax_3d_stream_core.sv
// ============================================================================
// stencil_relax_3d_stream_core : streaming 7-point weighted Jacobi sweep
// One item at a time: a transaction with no result returns to idle after the
// check; a boundary result reads only the centre tap, while an interior result
// takes the seven reads of the single window memory port, the difference,
// weighting and rounding steps and the five bytewise divide-by-six steps.
// Every result may then wait on the output register.
// Synchronous active-low reset clears counts and control registers and holds
// s_axis_tready low while a settle count runs down, as a grid_size write does.
// ============================================================================
module stencil_relax_3d_stream_core
    import srs_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [SAMPLE_W-1:0]     s_axis_tdata,   // [31:0] sample
    input  logic                    s_axis_tuser,   // [0] flush
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [SAMPLE_W-1:0]     m_axis_tdata,   // [31:0] value
    output logic                    m_axis_tlast
);

    localparam int DEPTH = 2 * MAX_N * MAX_N + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int N_W   = $clog2(MAX_N + 1);
    localparam int C_W   = $clog2(MAX_N);
    localparam int PL_W  = $clog2(MAX_N * MAX_N + 1);
    localparam int CNT_W = $clog2(MAX_N * MAX_N * MAX_N + 1);

    function automatic logic [10:0] div6_step(input logic [10:0] x);
        logic [20:0] m;
        logic [7:0]  q;
        logic [10:0] r;
        m = 21'(x) * RECIP6;
        q = m[19:12];
        r = x - (11'(q) << 2) - (11'(q) << 1);
        return {q, r[2:0]};
    endfunction

    t_state r_state, n_state;

    logic [GRID_SIZE_W-1:0] r_grid_size;
    logic [OMEGA_W-1:0]     r_omega;
    logic [1:0]             r_cfg_wait;
    logic [N_W-1:0]         r_n;
    logic [PL_W-1:0]        r_plane;
    logic [CNT_W-1:0]       r_total;

    logic [CNT_W-1:0] r_in_cnt, r_out_cnt;
    logic [AW-1:0]    r_in_addr, r_out_addr;
    logic [C_W-1:0]   r_oi, r_oj, r_ok;
    logic             r_is_edge;
    t_tap             r_tap;
    logic             r_rd_vld;
    t_tap             r_rd_tag;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic [SAMPLE_W-1:0] r_window [DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;

    logic signed [SAMPLE_W-1:0] r_s;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [DIFF_W-1:0]   r_diff;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [NUM_W-1:0]    r_num;
    logic                       r_neg;
    logic [DIV_W-1:0]           r_div_in;
    logic [2:0]                 r_rem;
    logic [SAMPLE_W-1:0]        r_res;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_data;
    logic                r_out_last;

    logic            accept;
    logic            mem_we;
    logic            cfg_grid_we;
    logic            emit;
    logic            out_free;
    logic            last_tap;
    logic [C_W-1:0]  n_last;
    logic [AW-1:0]   rd_addr;
    logic [AW:0]     off_ext;
    logic [AW:0]     addr_sum;
    logic [AW:0]     addr_dif;
    logic [31:0]     gs32;
    logic [PL_W-1:0] n_pl;
    logic [CNT_W-1:0] pl_c, n_c;
    logic [CNT_W:0]  p_plus;
    logic [10:0]     div_x;
    logic [10:0]     div_r;
    logic [NUM_W-1:0] rnd;
    logic signed [DIFF_W-1:0] s_d;
    logic signed [NUM_W-1:0]  s_n;

    assign s_axis_tready = (r_state == S_IDLE) && (r_cfg_wait == 2'd0);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mem_we        = accept && !s_axis_tuser && (r_in_cnt < r_total);
    assign cfg_grid_we   = i_cfg_we && (t_cfg_reg'(i_cfg_addr) == CFG_GRID_SIZE);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign n_last        = C_W'(r_n - N_W'(1));
    assign p_plus        = (CNT_W+1)'(r_out_cnt) + (CNT_W+1)'(r_plane);
    assign emit          = (r_out_cnt < r_in_cnt)
                           && ((p_plus < (CNT_W+1)'(r_in_cnt)) || (r_in_cnt == r_total));
    assign last_tap      = r_is_edge || (r_tap == TAP_K_HI);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // grid geometry
    assign gs32 = 32'(r_grid_size);
    assign n_pl = PL_W'(r_n);
    assign pl_c = CNT_W'(r_plane);
    assign n_c  = CNT_W'(r_n);

    always_ff @(posedge i_clk) begin
        if (gs32 < 32'(MIN_N)) begin
            r_n <= N_W'(MIN_N);
        end else if (gs32 > 32'(MAX_N)) begin
            r_n <= N_W'(MAX_N);
        end else begin
            r_n <= N_W'(gs32);
        end
        r_plane <= n_pl * n_pl;
        r_total <= pl_c * n_c;
    end

    // neighbour address on the ring
    always_comb begin
        case (r_tap)
            TAP_I_LO, TAP_I_HI: off_ext = (AW+1)'(r_plane);
            TAP_J_LO, TAP_J_HI: off_ext = (AW+1)'(r_n);
            TAP_K_LO, TAP_K_HI: off_ext = (AW+1)'(1);
            default:            off_ext = '0;
        endcase
        addr_sum = {1'b0, r_out_addr} + off_ext;
        addr_dif = {1'b0, r_out_addr} - off_ext;
        if (r_tap == TAP_I_LO || r_tap == TAP_J_LO || r_tap == TAP_K_LO) begin
            rd_addr = addr_dif[AW] ? AW'(addr_dif + (AW+1)'(DEPTH)) : AW'(addr_dif);
        end else begin
            rd_addr = (addr_sum >= (AW+1)'(DEPTH)) ? AW'(addr_sum - (AW+1)'(DEPTH))
                                                   : AW'(addr_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_window[r_in_addr] <= s_axis_tdata;
        end
        r_rd_data <= r_window[rd_addr];
    end

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else if (cfg_grid_we) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_CHECK;
            S_CHECK: n_state = emit ? S_READ : S_IDLE;
            S_READ:  if (last_tap) n_state = S_WAIT;
            S_WAIT:  n_state = r_is_edge ? S_OUT : S_DIFF;
            S_DIFF:  n_state = S_MUL;
            S_MUL:   n_state = S_NUM;
            S_NUM:   n_state = S_RND;
            S_RND:   n_state = S_DIV;
            S_DIV:   if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = S_SAT;
            S_SAT:   n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // counts, coordinates and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_SIZE_RST;
            r_omega     <= OMEGA_RST;
            r_cfg_wait  <= CFG_SETTLE;
            r_in_cnt    <= '0;
            r_out_cnt   <= '0;
            r_in_addr   <= '0;
            r_out_addr  <= '0;
            r_oi        <= '0;
            r_oj        <= '0;
            r_ok        <= '0;
            r_is_edge   <= 1'b0;
            r_tap       <= TAP_CENTRE;
            r_rd_vld    <= 1'b0;
            r_rd_tag    <= TAP_CENTRE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_cfg_wait != 2'd0 && !cfg_grid_we) begin
                r_cfg_wait <= r_cfg_wait - 2'd1;
            end
            r_rd_vld <= (r_state == S_READ);
            r_rd_tag <= r_tap;

            if (mem_we) begin
                r_in_cnt  <= r_in_cnt + CNT_W'(1);
                r_in_addr <= (r_in_addr == AW'(DEPTH - 1)) ? '0 : r_in_addr + AW'(1);
            end

            if (r_state == S_CHECK) begin
                r_tap     <= TAP_CENTRE;
                r_is_edge <= (r_oi == '0) || (r_oi == n_last) || (r_oj == '0)
                             || (r_oj == n_last) || (r_ok == '0) || (r_ok == n_last);
            end
            if (r_state == S_READ && !last_tap) begin
                r_tap <= t_tap'(3'(r_tap) + 3'd1);
            end
            if (r_state == S_RND) begin
                r_div_cnt <= '0;
            end
            if (r_state == S_DIV) begin
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end

            if (r_out_valid && m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
                if (r_out_cnt == r_total - CNT_W'(1)) begin
                    r_in_cnt   <= '0;
                    r_out_cnt  <= '0;
                    r_in_addr  <= '0;
                    r_out_addr <= '0;
                    r_oi       <= '0;
                    r_oj       <= '0;
                    r_ok       <= '0;
                end else begin
                    r_out_cnt  <= r_out_cnt + CNT_W'(1);
                    r_out_addr <= (r_out_addr == AW'(DEPTH - 1)) ? '0
                                                                 : r_out_addr + AW'(1);
                    if (r_ok == n_last) begin
                        r_ok <= '0;
                        if (r_oj == n_last) begin
                            r_oj <= '0;
                            r_oi <= r_oi + C_W'(1);
                        end else begin
                            r_oj <= r_oj + C_W'(1);
                        end
                    end else begin
                        r_ok <= r_ok + C_W'(1);
                    end
                end
            end

            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_addr))
                    CFG_GRID_SIZE: begin
                        r_grid_size <= i_cfg_wdata[GRID_SIZE_W-1:0];
                        r_cfg_wait  <= CFG_SETTLE;
                        r_in_cnt    <= '0;
                        r_out_cnt   <= '0;
                        r_in_addr   <= '0;
                        r_out_addr  <= '0;
                        r_oi        <= '0;
                        r_oj        <= '0;
                        r_ok        <= '0;
                    end
                    CFG_OMEGA: r_omega <= i_cfg_wdata[OMEGA_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // arithmetic
    assign s_d   = DIFF_W'(r_s);
    assign s_n   = NUM_W'(r_s);
    assign rnd   = r_num[NUM_W-1] ? (HALF_Q - NUM_W'(r_num)) : (NUM_W'(r_num) + HALF_Q);
    assign div_x = {r_rem, r_div_in[DIV_W-1 -: 8]};
    assign div_r = div6_step(div_x);

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_sum <= '0;
        end else if (r_rd_vld && r_rd_tag != TAP_CENTRE) begin
            r_sum <= r_sum + SUM_W'($signed(r_rd_data));
        end
        if (r_rd_vld && r_rd_tag == TAP_CENTRE) begin
            r_s <= $signed(r_rd_data);
        end

        if (r_state == S_DIFF) begin
            r_diff <= (s_d <<< 2) + (s_d <<< 1) - DIFF_W'(r_sum);
        end
        if (r_state == S_MUL) begin
            r_prod <= r_diff * $signed({1'b0, r_omega});
        end
        if (r_state == S_NUM) begin
            r_num <= (s_n <<< 18) + (s_n <<< 17) - NUM_W'(r_prod);
        end
        if (r_state == S_RND) begin
            r_neg    <= r_num[NUM_W-1];
            r_div_in <= rnd[NUM_W-1 -: DIV_W];
            r_rem    <= '0;
        end
        if (r_state == S_DIV) begin
            r_div_in <= {r_div_in[DIV_W-9:0], div_r[10:3]};
            r_rem    <= div_r[2:0];
        end
        if (r_state == S_SAT) begin
            if (!r_neg) begin
                r_res <= (r_div_in > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                            : r_div_in[SAMPLE_W-1:0];
            end else begin
                r_res <= (r_div_in > DIV_W'(32'h8000_0000)) ? 32'h8000_0000
                                                            : 32'd0 - r_div_in[SAMPLE_W-1:0];
            end
        end
        if (r_state == S_OUT && out_free) begin
            r_out_data <= r_is_edge ? r_s : r_res;
            r_out_last <= (r_out_cnt == r_total - CNT_W'(1));
        end
    end

    a_out_behind_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_cnt <= r_in_cnt)
        else $error("output count ran ahead of input count");

    a_ready_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_rd_vld)
        else $error("input ready while a window read is in flight");

    a_interior_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_is_edge && !$past(cfg_grid_we))
            |-> ($past(r_state) == S_SAT || $past(r_state) == S_OUT))
        else $error("interior result issued without passing the divider");

endmodule

// File: test/stencil_relax_3d_stream_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// stencil_relax_3d_stream_core_tb : self-checking bench for the 3D Jacobi core
// Streams cubic grids through the core. A scoreboard keeps its own copy of the
// plane window and the relaxation arithmetic, and predicts every output
// transaction. It checks value and last flag in order. Covers a checkerboard
// of extreme values, out-of-range and mid-grid size writes, the whole weight
// range, and a partial 64-cube grid after an oversize size write. Then random
// grids run with stray flushes, aborted grids and surplus drain transactions,
// under random idling and back-pressure on both sides.
// ============================================================================
module stencil_relax_3d_stream_core_tb;
    import srs_pkg::*;

    localparam int     STORE_DEPTH    = 2 * MAX_N_DEF * MAX_N_DEF + 1;
    localparam longint SCALE6         = 393216;
    localparam int     SETTLE_CYCLES  = 40;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     RANDOM_ITEMS   = 950;
    localparam int     LARGE_ITEMS    = 120;
    localparam int     REPORT_CAP     = 200;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                last_cell;
    } t_relaxed_cell;

    class relax_scoreboard;
        logic [SAMPLE_W-1:0]    window_words [STORE_DEPTH];
        int unsigned            cells_in;
        int unsigned            cells_out;
        logic [GRID_SIZE_W-1:0] grid_edge_reg;
        logic [OMEGA_W-1:0]     omega_reg;
        t_relaxed_cell          expected_cells [$];
        int                     mismatches;

        function new();
            cells_in      = 0;
            cells_out     = 0;
            grid_edge_reg = GRID_SIZE_RST;
            omega_reg     = OMEGA_RST;
            mismatches    = 0;
        endfunction

        function int unsigned side();
            if (grid_edge_reg < MIN_N) return MIN_N;
            if (grid_edge_reg > MAX_N_DEF) return MAX_N_DEF;
            return grid_edge_reg;
        endfunction

        function int pending();
            return expected_cells.size();
        endfunction

        function void apply_write(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_GRID_SIZE: begin
                    grid_edge_reg = val[GRID_SIZE_W-1:0];
                    cells_in      = 0;
                    cells_out     = 0;
                end
                CFG_OMEGA: begin
                    omega_reg = val[OMEGA_W-1:0];
                end
                default: ;
            endcase
        endfunction

        function longint word_at(int unsigned pos);
            logic signed [SAMPLE_W-1:0] w;
            w = window_words[pos % STORE_DEPTH];
            return w;
        endfunction

        function logic [SAMPLE_W-1:0] relax_cell(int unsigned p, int unsigned n);
            longint      centre, nsum, weight, num, mag, q;
            int unsigned plane;
            plane  = n * n;
            weight = omega_reg;
            centre = word_at(p);
            nsum   = word_at(p - plane) + word_at(p + plane) + word_at(p - n)
                   + word_at(p + n) + word_at(p - 1) + word_at(p + 1);
            num = SCALE6 * centre - weight * (6 * centre - nsum);
            mag = (num < 0) ? -num : num;
            q   = (mag + SCALE6 / 2) / SCALE6;
            if (num < 0) q = -q;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            return q[SAMPLE_W-1:0];
        endfunction

        function void note_input(logic [SAMPLE_W-1:0] smp, logic fl);
            int unsigned   n, plane, total, p, ci, cj, ck;
            logic          border;
            t_relaxed_cell exp_cell;
            n     = side();
            plane = n * n;
            total = plane * n;
            if (!fl && cells_in < total) begin
                window_words[cells_in % STORE_DEPTH] = smp;
                cells_in++;
            end
            p = cells_out;
            if (p < cells_in && (p + plane < cells_in || cells_in == total)) begin
                ci     = p / plane;
                cj     = (p / n) % n;
                ck     = p % n;
                border = ci == 0 || ci == n - 1 || cj == 0 || cj == n - 1
                      || ck == 0 || ck == n - 1;
                exp_cell.value     = border ? window_words[p % STORE_DEPTH]
                                            : relax_cell(p, n);
                exp_cell.last_cell = (p == total - 1);
                expected_cells.push_back(exp_cell);
                cells_out++;
                if (cells_out == total) begin
                    cells_out = 0;
                    cells_in  = 0;
                end
            end
        endfunction

        task report_mismatch(string msg);
            if (mismatches < REPORT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [SAMPLE_W-1:0] value, logic last_cell);
            t_relaxed_cell want;
            if (expected_cells.size() == 0) begin
                report_mismatch($sformatf("unexpected cell %h last %b", value, last_cell));
                return;
            end
            want = expected_cells.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("value %h, expected %h", value, want.value));
            if (last_cell !== want.last_cell)
                report_mismatch($sformatf("last %b, expected %b", last_cell, want.last_cell));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [SAMPLE_W-1:0]   m_axis_tdata;
    logic                  m_axis_tlast;

    relax_scoreboard sb;
    int              items_sent   = 0;
    int              idle_pct     = 10;
    int              rx_hold_len  = 0;
    int              stall_cycles = 0;

    stencil_relax_3d_stream_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return $urandom;
            default: return $urandom_range(1 << 20) - (1 << 19);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_omega();
        case ($urandom_range(5))
            0:       return '0;
            1:       return 18'd131072;
            2:       return OMEGA_RST;
            3:       return CFG_DATA_W'($urandom_range(131073, 262143));
            default: return CFG_DATA_W'($urandom_range(131072));
        endcase
    endfunction

    task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic fl);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= fl;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(smp, fl);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.apply_write(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // output side: random back-pressure, plus a long hold-off on request
    initial begin : rx_side
        int hold;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_len != 0) begin
                hold        = rx_hold_len;
                rx_hold_len = 0;
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL stencil_relax_3d_stream_core");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int   n, total, abort_at, grid_no;
        logic force_write;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // 4-cube of alternating extremes with a weight above 2.0: saturates
        write_reg(CFG_GRID_SIZE, 18'h3FF80);
        write_reg(CFG_OMEGA, 18'h3FFFF);
        send_item(32'h0, 1'b1);
        for (int c = 0; c < 64; c++) begin
            if (c == 30) send_item(32'h1234_5678, 1'b1);
            send_item((((c >> 4) ^ (c >> 2) ^ c) & 1) ? 32'h7FFF_FFFF : 32'h8000_0000, 1'b0);
        end
        for (int c = 0; sb.cells_in != 0; c++) begin
            case (c % 3)
                0:       send_item(32'h0, 1'b0);
                1:       send_item(32'hFFFF_FFFF, 1'b0);
                default: send_item($urandom, 1'b1);
            endcase
        end
        send_item($urandom, 1'b1);

        // drop a partly streamed grid
        wait_drained();
        write_reg(CFG_OMEGA, '0);
        for (int c = 0; c < 10; c++) send_item(rand_sample(), 1'b0);
        wait_drained();
        write_reg(CFG_GRID_SIZE, 18'd5);
        write_reg(CFG_OMEGA, 18'd131072);

        // oversize request clamps to 64: partial grid, dropped by the next size write
        write_reg(CFG_GRID_SIZE, 18'd100);
        write_reg(CFG_OMEGA, pick_omega());
        for (int c = 0; c < LARGE_ITEMS; c++) send_item(rand_sample(), 1'b0);
        wait_drained();

        grid_no     = 0;
        force_write = 1'b1;
        while (items_sent < RANDOM_ITEMS) begin
            if (force_write || $urandom_range(2) != 0) begin
                wait_drained();
                n = $urandom_range(4, 6);
                write_reg(CFG_GRID_SIZE, (n == 4 && $urandom_range(1) == 1) ?
                          18'($urandom_range(3)) : 18'(n));
                if (force_write || $urandom_range(1) == 1) write_reg(CFG_OMEGA, pick_omega());
                force_write = 1'b0;
            end
            n        = sb.side();
            total    = n * n * n;
            idle_pct = (grid_no == 2) ? 0 : 10;
            if (grid_no == 1) rx_hold_len = 400;
            abort_at = (grid_no > 2 && $urandom_range(9) == 0) ?
                       $urandom_range(1, total - 1) : total;
            for (int c = 0; c < abort_at; c++) begin
                if (grid_no == 1 && c == total / 2) wait_drained();
                if ($urandom_range(29) == 0) send_item($urandom, 1'b1);
                send_item(rand_sample(), 1'b0);
            end
            if (abort_at < total) begin
                force_write = 1'b1;
            end else begin
                while (sb.cells_in != 0) send_item(rand_sample(), $urandom_range(3) != 0);
                if ($urandom_range(3) == 0) send_item($urandom, 1'b1);
            end
            grid_no++;
        end

        wait_drained();
        if (sb.mismatches == 0) begin
            $display("PASS stencil_relax_3d_stream_core");
        end else begin
            $display("FAIL stencil_relax_3d_stream_core");
        end
        $finish;
    end

endmodule
